// ----- src/pla_pkg.sv -----
// Shared constants, codes and types for the positional list array.
`default_nettype none

package pla_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int POS_W      = 5;
  localparam int VAL_W      = 32;
  localparam int LEN_W      = 5;
  localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SH_RD,
    S_SH_WR,
    S_PUT,
    S_TAKE,
    S_RM_RD,
    S_RM_WR
  } state_t;

  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } mem_req_t;

  typedef struct packed {
    status_t          status;
    logic             is_empty;
    logic [LEN_W-1:0] length;
    logic [VAL_W-1:0] value;
  } res_t;

endpackage

`default_nettype wire

// ----- src/pla_mem.sv -----
// Entry store: one write port and one registered read port.
`default_nettype none

module pla_mem (
  input  wire                                  clk,
  input  wire pla_pkg::mem_req_t               req,
  output logic [pla_pkg::DATA_WIDTH-1:0]       rdata
);

  logic [pla_pkg::DATA_WIDTH-1:0] mem [pla_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/pla_ctrl.sv -----
// Sequencer: checks each operation and walks the shift one entry at a time.
`default_nettype none

module pla_ctrl (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  in_valid,
  output logic                                 in_ready,
  input  wire  [1:0]                           in_op,
  input  wire  [pla_pkg::POS_W-1:0]            in_pos,
  input  wire  [pla_pkg::VAL_W-1:0]            in_word,
  input  wire                                  out_free,
  output logic                                 done,
  output pla_pkg::res_t                        res,
  output pla_pkg::mem_req_t                    mem,
  input  wire  [pla_pkg::DATA_WIDTH-1:0]       rdata
);

  pla_pkg::state_t                state, state_next;
  logic [pla_pkg::CNT_W-1:0]      cnt, cnt_next;
  logic [pla_pkg::IDX_W-1:0]      cur, cur_next;
  logic [pla_pkg::IDX_W-1:0]      pidx, pidx_next;
  logic [pla_pkg::DATA_WIDTH-1:0] word, word_next;
  logic [pla_pkg::DATA_WIDTH-1:0] taken, taken_next;

  logic                           accept;
  logic [pla_pkg::CMP_W-1:0]      pos_ext, cnt_ext;
  logic                           read_bad, ins_bad;
  logic [pla_pkg::IDX_W-1:0]      in_pidx;
  logic [pla_pkg::DATA_WIDTH-1:0] res_value;
  logic [pla_pkg::CNT_W-1:0]      res_len;
  pla_pkg::status_t               res_status;

  assign in_ready = (state == pla_pkg::S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign pos_ext  = pla_pkg::CMP_W'(in_pos);
  assign cnt_ext  = pla_pkg::CMP_W'(cnt);
  assign read_bad = (in_pos == '0) || (pos_ext > cnt_ext);
  assign ins_bad  = (in_pos == '0) || (pos_ext > cnt_ext + pla_pkg::CMP_W'(1));
  assign in_pidx  = pla_pkg::IDX_W'(pos_ext - pla_pkg::CMP_W'(1));

  assign res.value    = pla_pkg::VAL_W'(res_value);
  assign res.length   = pla_pkg::LEN_W'(res_len);
  assign res.is_empty = (res_len == '0);
  assign res.status   = res_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pla_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    pidx  <= pidx_next;
    word  <= word_next;
    taken <= taken_next;
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cur_next   = cur;
    pidx_next  = pidx;
    word_next  = word;
    taken_next = taken;
    done       = 1'b0;
    res_value  = '0;
    res_len    = cnt;
    res_status = pla_pkg::ST_OK;
    mem        = '0;
    unique case (state)
      pla_pkg::S_IDLE: begin
        if (accept) begin
          case (in_op)
            pla_pkg::OP_READ: begin
              if (read_bad) begin
                done       = 1'b1;
                res_status = pla_pkg::ST_RANGE;
              end else begin
                mem.re     = 1'b1;
                mem.raddr  = in_pidx;
                state_next = pla_pkg::S_READ;
              end
            end
            pla_pkg::OP_INSERT: begin
              if (cnt == pla_pkg::CNT_W'(pla_pkg::DEPTH)) begin
                done       = 1'b1;
                res_status = pla_pkg::ST_FULL;
              end else if (ins_bad) begin
                done       = 1'b1;
                res_status = pla_pkg::ST_RANGE;
              end else begin
                pidx_next = in_pidx;
                word_next = pla_pkg::DATA_WIDTH'(in_word);
                cur_next  = pla_pkg::IDX_W'(cnt);
                // appending at the end needs no shift
                if (pos_ext == cnt_ext + pla_pkg::CMP_W'(1)) begin
                  state_next = pla_pkg::S_PUT;
                end else begin
                  state_next = pla_pkg::S_SH_RD;
                end
              end
            end
            pla_pkg::OP_REMOVE: begin
              if (cnt == '0) begin
                done       = 1'b1;
                res_status = pla_pkg::ST_EMPTY;
              end else if (read_bad) begin
                done       = 1'b1;
                res_status = pla_pkg::ST_RANGE;
              end else begin
                mem.re     = 1'b1;
                mem.raddr  = in_pidx;
                pidx_next  = in_pidx;
                state_next = pla_pkg::S_TAKE;
              end
            end
            default: begin
              done       = 1'b1;
              res_status = pla_pkg::ST_RANGE;
            end
          endcase
        end
      end
      pla_pkg::S_READ: begin
        done       = 1'b1;
        res_value  = rdata;
        state_next = pla_pkg::S_IDLE;
      end
      pla_pkg::S_SH_RD: begin
        mem.re     = 1'b1;
        mem.raddr  = cur - pla_pkg::IDX_W'(1);
        state_next = pla_pkg::S_SH_WR;
      end
      pla_pkg::S_SH_WR: begin
        mem.we    = 1'b1;
        mem.waddr = cur;
        mem.wdata = rdata;
        cur_next  = cur - pla_pkg::IDX_W'(1);
        if (cur - pla_pkg::IDX_W'(1) == pidx) begin
          state_next = pla_pkg::S_PUT;
        end else begin
          state_next = pla_pkg::S_SH_RD;
        end
      end
      pla_pkg::S_PUT: begin
        mem.we     = 1'b1;
        mem.waddr  = pidx;
        mem.wdata  = word;
        cnt_next   = cnt + pla_pkg::CNT_W'(1);
        done       = 1'b1;
        res_len    = cnt + pla_pkg::CNT_W'(1);
        state_next = pla_pkg::S_IDLE;
      end
      pla_pkg::S_TAKE: begin
        taken_next = rdata;
        if (pla_pkg::CNT_W'(pidx) + pla_pkg::CNT_W'(1) == cnt) begin
          // removed the last entry: nothing to close up
          cnt_next   = cnt - pla_pkg::CNT_W'(1);
          done       = 1'b1;
          res_value  = rdata;
          res_len    = cnt - pla_pkg::CNT_W'(1);
          state_next = pla_pkg::S_IDLE;
        end else begin
          cur_next   = pidx + pla_pkg::IDX_W'(1);
          state_next = pla_pkg::S_RM_RD;
        end
      end
      pla_pkg::S_RM_RD: begin
        mem.re     = 1'b1;
        mem.raddr  = cur;
        state_next = pla_pkg::S_RM_WR;
      end
      pla_pkg::S_RM_WR: begin
        mem.we    = 1'b1;
        mem.waddr = cur - pla_pkg::IDX_W'(1);
        mem.wdata = rdata;
        if (pla_pkg::CNT_W'(cur) + pla_pkg::CNT_W'(1) == cnt) begin
          cnt_next   = cnt - pla_pkg::CNT_W'(1);
          done       = 1'b1;
          res_value  = taken;
          res_len    = cnt - pla_pkg::CNT_W'(1);
          state_next = pla_pkg::S_IDLE;
        end else begin
          cur_next   = cur + pla_pkg::IDX_W'(1);
          state_next = pla_pkg::S_RM_RD;
        end
      end
      default: begin
        state_next = pla_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- src/positional_list_array.sv -----
// Positional list array: top level with stream ports and the result register.
// The sequencer takes one item at a time: the next item is taken once it is
// idle and the result register is free. An insert or remove shifts the entries
// one at a time, each read from the registered read port of the entry store
// and then written one place over. Reset (rst, synchronous) empties the list
// and drops any pending result; entry contents are not cleared.
`default_nettype none

module positional_list_array (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // s_tdata fields from bit 0: op[1:0], position[6:2], write_value[38:7], zero pad[39]
  input  wire  [39:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // m_tdata fields from bit 0: read_value[31:0], length[36:32], is_empty[37],
  // status[39:38]
  output logic [39:0] m_tdata
);

  logic                           done;
  logic                           out_free;
  pla_pkg::res_t                  res;
  pla_pkg::res_t                  out_res;
  pla_pkg::mem_req_t              mem_req;
  logic [pla_pkg::DATA_WIDTH-1:0] rdata;

  // the result register frees up in the same cycle it is taken
  assign out_free = !m_tvalid || m_tready;

  pla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tdata[1:0]),
    .in_pos   (s_tdata[6:2]),
    .in_word  (s_tdata[38:7]),
    .out_free (out_free),
    .done     (done),
    .res      (res),
    .mem      (mem_req),
    .rdata    (rdata)
  );

  pla_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.status, out_res.is_empty, out_res.length, out_res.value};

endmodule

`default_nettype wire

// ----- src/pla_checker.sv -----
// Port-level checks for the positional list array, bound to the top level.
`default_nettype none

module pla_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [39:0] m_tdata
);

  logic [4:0] length_q;

  assign length_q = m_tdata[36:32];

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped or changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[37] == (length_q == 5'd0)))
    else $error("empty flag disagrees with length");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:38] != pla_pkg::ST_OK) |-> (m_tdata[31:0] == 32'd0))
    else $error("rejected operation returned a nonzero word");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (length_q <= 5'(pla_pkg::DEPTH)))
    else $error("length above list depth");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind positional_list_array pla_checker u_pla_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
